// File: hdl/spu_pkg.sv
// shared types, constants and coefficient table of the sine polynomial unit
package spu_pkg;

  localparam logic [26:0] TAU = 27'd105414357;

  typedef struct packed {
    logic [63:0]        p;
    logic [61:0]        th2;
    logic signed [27:0] th;
  } horner_t;

  function automatic logic [63:0] coef(input int k);
    logic [63:0] c;
    case (k)
      0:       c = 64'sd72057594037927936;
      1:       c = -64'sd12009599006321322;
      2:       c = 64'sd600479950316066;
      3:       c = -64'sd14297141674192;
      4:       c = 64'sd198571412142;
      5:       c = -64'sd1805194656;
      6:       c = 64'sd11571761;
      7:       c = -64'sd55104;
      8:       c = 64'sd203;
      9:       c = -64'sd1;
      default: c = 64'd0;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/spu_reduce.sv
// range reduction by two pi and squaring of the reduced angle
module spu_reduce (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic signed [31:0] ang,
  output logic               out_vld,
  output logic signed [27:0] th,
  output logic [61:0]        th2
);

  localparam logic [21:0] RECIP = 22'((64'd1 << 48) / spu_pkg::TAU);

  logic [4:0]         vld_r;
  logic               sgn1_r, sgn2_r, sgn3_r;
  logic [31:0]        mag1_r, mag2_r;
  logic [4:0]         q_r;
  logic [27:0]        rem_r;
  logic signed [27:0] th4_r, th5_r;
  logic [61:0]        th2_r;

  logic [53:0]        prod;
  logic [31:0]        qtau;
  logic [31:0]        rem_nxt;
  logic [27:0]        rem_c;
  logic signed [27:0] th_nxt;
  logic signed [55:0] sq;

  always_comb begin
    prod    = mag1_r * RECIP;
    qtau    = {27'b0, q_r} * {5'b0, spu_pkg::TAU};
    rem_nxt = mag2_r - qtau;
    rem_c   = (rem_r >= 28'(spu_pkg::TAU)) ? rem_r - 28'(spu_pkg::TAU) : rem_r;
    th_nxt  = sgn3_r ? -$signed({1'b0, rem_c[26:0]}) : $signed({1'b0, rem_c[26:0]});
    sq      = th4_r * th4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sgn1_r <= ang[31];
      mag1_r <= ang[31] ? 32'(-ang) : 32'(ang);
      sgn2_r <= sgn1_r;
      mag2_r <= mag1_r;
      q_r    <= prod[52:48];
      sgn3_r <= sgn2_r;
      rem_r  <= rem_nxt[27:0];
      th4_r  <= th_nxt;
      th5_r  <= th4_r;
      th2_r  <= {sq[53:0], 8'b0};
    end
  end

  assign out_vld = vld_r[4];
  assign th      = th5_r;
  assign th2     = th2_r;

endmodule

// File: hdl/spu_horner_step.sv
// one horner step: split multiply, partial product sum, coefficient add
module spu_horner_step #(
  parameter logic [63:0] COEF = 64'd0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  spu_pkg::horner_t  in_d,
  output logic              out_vld,
  output spu_pkg::horner_t  out_d
);

  logic [2:0]        vld_r;
  logic [62:0]       ll_r, lh_r;
  logic signed [63:0] hl_r, hh_r;
  logic [127:0]      sum_r;
  spu_pkg::horner_t  d1_r, d2_r, d3_r;

  logic [127:0]      sum_nxt;

  always_comb begin
    sum_nxt = {hh_r[63], hh_r, 63'b0}
            + {{32{hl_r[63]}}, hl_r, 32'b0}
            + {34'b0, lh_r, 31'b0}
            + {65'b0, ll_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r   <= {31'b0, in_d.p[31:0]} * {32'b0, in_d.th2[30:0]};
      lh_r   <= {31'b0, in_d.p[31:0]} * {32'b0, in_d.th2[61:31]};
      hl_r   <= $signed(in_d.p[63:32]) * $signed({1'b0, in_d.th2[30:0]});
      hh_r   <= $signed(in_d.p[63:32]) * $signed({1'b0, in_d.th2[61:31]});
      d1_r   <= in_d;
      sum_r  <= sum_nxt;
      d2_r   <= d1_r;
      d3_r.p   <= COEF + sum_r[119:56];
      d3_r.th2 <= d2_r.th2;
      d3_r.th  <= d2_r.th;
    end
  end

  assign out_vld = vld_r[2];
  assign out_d   = d3_r;

endmodule

// File: hdl/spu_final.sv
// final multiply by the angle, scaling to q2.30 and saturation
module spu_final (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  spu_pkg::horner_t   in_d,
  output logic               out_vld,
  output logic signed [31:0] sine
);

  localparam logic signed [45:0] ONE = 46'sd1073741824;

  logic [2:0]         vld_r;
  logic signed [60:0] mlo_r;
  logic signed [59:0] mhi_r;
  logic signed [45:0] r_r;
  logic signed [31:0] sine_r;

  logic [95:0]        sum;

  always_comb begin
    sum = {{4{mhi_r[59]}}, mhi_r, 32'b0} + {{35{mlo_r[60]}}, mlo_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mlo_r <= $signed({1'b0, in_d.p[31:0]}) * in_d.th;
      mhi_r <= $signed(in_d.p[63:32]) * in_d.th;
      r_r   <= $signed(sum[95:50]);
      if (r_r > ONE) begin
        sine_r <= 32'(ONE);
      end else if (r_r < -ONE) begin
        sine_r <= 32'(-ONE);
      end else begin
        sine_r <= r_r[31:0];
      end
    end
  end

  assign out_vld = vld_r[2];
  assign sine    = sine_r;

endmodule

// File: hdl/sine_polynomial_unit.sv
// top level of the pipelined fixed-point sine unit
//   channel | direction | ports
//   in      | input     | in_valid, in_ready, in_angle (q8.24)
//   out     | output    | out_valid, out_ready, out_sine_value (q2.30)
// one angle per cycle is accepted, except while the pipeline holds
// (5 reduction stages, 3 per horner step, 3 for the final multiply)
// the whole pipeline holds when a result waits and out_ready is low
// synchronous reset clears every valid bit; data registers are not reset
module sine_polynomial_unit #(
  parameter int NUM_TERMS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_sine_value
);

  localparam int STEPS = NUM_TERMS - 1;

  logic               en;
  logic               red_vld;
  logic signed [27:0] red_th;
  logic [61:0]        red_th2;
  logic               vld [0:STEPS];
  spu_pkg::horner_t   dat [0:STEPS];

  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  spu_reduce u_reduce (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .ang     (in_angle),
    .out_vld (red_vld),
    .th      (red_th),
    .th2     (red_th2)
  );

  assign vld[0]     = red_vld;
  assign dat[0].p   = spu_pkg::coef(NUM_TERMS - 1);
  assign dat[0].th2 = red_th2;
  assign dat[0].th  = red_th;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    spu_horner_step #(
      .COEF (spu_pkg::coef(NUM_TERMS - 2 - i))
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (vld[i]),
      .in_d    (dat[i]),
      .out_vld (vld[i+1]),
      .out_d   (dat[i+1])
    );
  end

  spu_final u_final (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (vld[STEPS]),
    .in_d    (dat[STEPS]),
    .out_vld (out_valid),
    .sine    (out_sine_value)
  );

endmodule

// File: hdl/spu_checker.sv
// port-level checks of the sine polynomial unit, bound to the top level
module spu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_sine_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sine_value))
    else $error("result changed before transfer");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sine_value <= 32'sd1073741824) &&
                  (out_sine_value >= -32'sd1073741824))
    else $error("sine outside saturation range");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input held off without output stall");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sine_polynomial_unit spu_checker u_spu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_sine_value (out_sine_value)
);
